FILE: hw/rtl/serial_line_editor_top_macros.svh
// Assertion macros used by the sequencer of the serial line editor.
`ifndef SERIAL_LINE_EDITOR_TOP_MACROS_SVH
`define SERIAL_LINE_EDITOR_TOP_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SLE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define SLE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define SLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sle_pkg.sv
// Shared types, character codes and echo sequence functions of the serial line editor.
package sle_pkg;

    localparam logic [7:0] KEY_ENTER   = 8'd13;
    localparam logic [7:0] KEY_BACK    = 8'd8;
    localparam logic [7:0] CHR_SPACE   = 8'd32;
    localparam logic [7:0] CHR_NEWLINE = 8'd10;

    localparam logic [1:0] KIND_ECHO  = 2'd0;
    localparam logic [1:0] KIND_CMD   = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // Position within an echo sequence.
    localparam logic [1:0] STEP_FIRST  = 2'd0;
    localparam logic [1:0] STEP_SECOND = 2'd1;
    localparam logic [1:0] STEP_THIRD  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ECHO,
        ST_DUMP_RD,
        ST_DUMP_OUT
    } sle_state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       last;
    } sle_res_t;

    // Echo sequences: backspace gives BS, space, BS; enter gives newline, CR.
    function automatic logic [7:0] echo_char(input logic back_mode, input logic [1:0] step);
        logic [7:0] ch;
        if (back_mode) begin
            ch = (step == STEP_SECOND) ? CHR_SPACE : KEY_BACK;
        end
        else begin
            ch = (step == STEP_FIRST) ? CHR_NEWLINE : KEY_ENTER;
        end
        return ch;
    endfunction

    function automatic logic echo_final(input logic back_mode, input logic [1:0] step);
        logic fin;
        if (back_mode) begin
            fin = (step == STEP_THIRD);
        end
        else begin
            fin = (step == STEP_SECOND);
        end
        return fin;
    endfunction

endpackage

FILE: hw/rtl/serial_line_editor_top.sv
// Serial line editor: assembles a command line from received bytes and emits echoes and lines.
// A lone result beat is pushed from the decode state into the output register; the first echo of
// a backspace or enter is pushed from the echo state, after decode. Further echoes follow each cycle
// unless the consumer stalls; each line byte takes a store read state and then an output state.
// Input is stalled outside idle, so a byte is taken only once all beats of the last are pushed.
// Reset clears the sequencer and the fill count at once; the line store itself is not cleared.
module serial_line_editor_top #(
    parameter int MAX_LEN = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic       last
);
    import sle_pkg::*;

    // Address width of the line store and width of the fill count, which must hold MAX_LEN.
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W  = $clog2(MAX_LEN + 1);

    logic              out_ready;
    logic              push;
    sle_res_t          res;
    sle_res_t          res_q;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    // The sequencer takes one byte, then walks its echo or dump sequence beat by beat.
    sle_ctrl #(
        .MAX_LEN (MAX_LEN),
        .ADDR_W  (ADDR_W),
        .CNT_W   (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_byte   (rx_byte),
        .out_ready (out_ready),
        .push      (push),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // The line store holds the bytes typed so far; read data is registered and comes back in the cycle after the read.
    sle_line_ram #(
        .MAX_LEN (MAX_LEN),
        .ADDR_W  (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The output register lets the sequencer move on while a beat waits for the consumer.
    sle_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res_in    (res),
        .ready     (out_ready),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_out   (res_q)
    );

    assign kind     = res_q.kind;
    assign out_byte = res_q.out_byte;
    assign last     = res_q.last;

endmodule

FILE: hw/rtl/sle_line_ram.sv
// Line store: one write port and one registered read port.
module sle_line_ram #(
    parameter int MAX_LEN = 32,
    parameter int ADDR_W  = 5
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);
    import sle_pkg::*;

    logic [7:0] mem [MAX_LEN];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read, so a stalled output can wait on it.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/sle_out_reg.sv
// Output register that holds one result beat towards the consumer.
module sle_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sle_pkg::sle_res_t res_in,
    output logic             ready,
    output logic             res_valid,
    input  logic             res_stall,
    output sle_pkg::sle_res_t res_out
);
    import sle_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    sle_res_t data_reg;

    assign ready = !valid_reg || !res_stall;

    always_comb
    begin
        if (push && ready)
        begin
            valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && ready)
        begin
            data_reg <= res_in;
        end
    end

    assign res_valid = valid_reg;
    assign res_out   = data_reg;

endmodule

FILE: hw/rtl/sle_ctrl.sv
// Sequencer: decodes each received byte, keeps the fill count, drives the line store.
`include "serial_line_editor_top_macros.svh"

module sle_ctrl #(
    parameter int MAX_LEN = 32,
    parameter int ADDR_W  = 5,
    parameter int CNT_W   = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_stall,
    input  logic [7:0]        rx_byte,
    input  logic              out_ready,
    output logic              push,
    output sle_pkg::sle_res_t res,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [7:0]        rd_data
);
    import sle_pkg::*;

    sle_state_t        state_reg, state_next;
    logic [7:0]        byte_reg, byte_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [1:0]        step_reg, step_next;
    logic              back_mode_reg, back_mode_next;

    logic count_zero;
    logic has_room;
    logic echo_done;
    logic dump_last;

    assign count_zero = (count_reg == '0);
    assign has_room   = (count_reg < CNT_W'(MAX_LEN));
    assign echo_done  = echo_final(back_mode_reg, step_reg);
    assign dump_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (rx_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (byte_reg)
                    KEY_ENTER:
                    begin
                        if (!count_zero)
                        begin
                            state_next = ST_ECHO;
                        end
                        else if (out_ready)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    KEY_BACK:
                    begin
                        state_next = count_zero ? ST_IDLE : ST_ECHO;
                    end
                    default:
                    begin
                        if (!has_room || out_ready)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_ECHO:
            begin
                if (out_ready && echo_done)
                begin
                    state_next = back_mode_reg ? ST_IDLE : ST_DUMP_RD;
                end
            end
            ST_DUMP_RD:
            begin
                state_next = ST_DUMP_OUT;
            end
            ST_DUMP_OUT:
            begin
                if (out_ready)
                begin
                    state_next = dump_last ? ST_IDLE : ST_DUMP_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs towards the receiver, the output register and the line store.
    always_comb
    begin
        rx_stall     = (state_reg != ST_IDLE);
        push         = 1'b0;
        res.kind     = KIND_ECHO;
        res.out_byte = byte_reg;
        res.last     = 1'b1;
        wr_en        = 1'b0;
        wr_addr      = count_reg[ADDR_W-1:0];
        wr_data      = byte_reg;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;
        case (state_reg)
            ST_DECODE:
            begin
                case (byte_reg)
                    KEY_ENTER:
                    begin
                        if (count_zero)
                        begin
                            push         = out_ready;
                            res.kind     = KIND_EMPTY;
                            res.out_byte = 8'd0;
                        end
                    end
                    KEY_BACK:
                    begin
                        push = 1'b0;
                    end
                    default:
                    begin
                        if (has_room)
                        begin
                            push  = out_ready;
                            wr_en = out_ready;
                        end
                    end
                endcase
            end
            ST_ECHO:
            begin
                push         = out_ready;
                res.out_byte = echo_char(back_mode_reg, step_reg);
                res.last     = back_mode_reg && echo_done;
            end
            ST_DUMP_RD:
            begin
                rd_en = 1'b1;
            end
            ST_DUMP_OUT:
            begin
                push         = out_ready;
                res.kind     = KIND_CMD;
                res.out_byte = rd_data;
                res.last     = dump_last;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        byte_next      = byte_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        back_mode_next = back_mode_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (rx_valid)
                begin
                    byte_next = rx_byte;
                end
            end
            ST_DECODE:
            begin
                case (byte_reg)
                    KEY_ENTER:
                    begin
                        back_mode_next = 1'b0;
                        step_next      = STEP_FIRST;
                        idx_next       = '0;
                    end
                    KEY_BACK:
                    begin
                        back_mode_next = 1'b1;
                        step_next      = STEP_FIRST;
                        if (!count_zero)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        if (has_room && out_ready)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                endcase
            end
            ST_ECHO:
            begin
                if (out_ready)
                begin
                    step_next = step_reg + 2'd1;
                end
            end
            ST_DUMP_OUT:
            begin
                if (out_ready)
                begin
                    if (dump_last)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        idx_reg       <= idx_next;
        step_reg      <= step_next;
        back_mode_reg <= back_mode_next;
    end

    `SLE_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(MAX_LEN),
        "fill count beyond line length")
    `SLE_ASSERT_SAME(a_write_room, wr_en, has_room && (state_reg == ST_DECODE),
        "store write without room")
    `SLE_ASSERT_NEXT(a_dump_clears, push && (res.kind == KIND_CMD) && res.last,
        count_reg == '0, "line not emptied after dump")
    `SLE_ASSERT_NEXT(a_back_dec,
        (state_reg == ST_DECODE) && (byte_reg == KEY_BACK) && !count_zero,
        count_reg == ($past(count_reg) - CNT_W'(1)), "backspace did not shorten line")

endmodule

FILE: tb/tb_serial_line_editor_top.sv
// Self-checking testbench for the serial line editor, with a line-mirroring scoreboard.
`timescale 1ns / 100ps

module tb_serial_line_editor_top;
    import sle_pkg::*;

    localparam int LINE_MAX    = 32;
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 110;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;

    // The scoreboard keeps its own copy of the line being typed and the queue of
    // result beats that the bytes accepted so far must still produce.
    class line_scoreboard;
        logic [7:0]  line_copy [LINE_MAX];
        int unsigned fill;
        sle_res_t    pending [$];
        int unsigned errors;
        int unsigned checked;
        int unsigned lines_dumped;
        int unsigned dropped;

        function new();
            fill = 0;
            errors = 0;
            checked = 0;
            lines_dumped = 0;
            dropped = 0;
        endfunction

        function void add_beat(logic [1:0] k, logic [7:0] b, logic l);
            sle_res_t beat;
            beat.kind = k;
            beat.out_byte = b;
            beat.last = l;
            pending.push_back(beat);
        endfunction

        // Works out the beats that one accepted byte causes; returns how many.
        function int note_byte(logic [7:0] c);
            int before_size;
            before_size = pending.size();
            if (c == KEY_ENTER)
            begin
                if (fill == 0)
                begin
                    add_beat(KIND_EMPTY, 8'h00, 1'b1);
                end
                else
                begin
                    add_beat(KIND_ECHO, CHR_NEWLINE, 1'b0);
                    add_beat(KIND_ECHO, KEY_ENTER, 1'b0);
                    for (int i = 0; i < fill; i++)
                    begin
                        add_beat(KIND_CMD, line_copy[i], (i + 1 == fill));
                    end
                    fill = 0;
                    lines_dumped++;
                end
            end
            else if (c == KEY_BACK)
            begin
                if (fill != 0)
                begin
                    fill--;
                    add_beat(KIND_ECHO, KEY_BACK, 1'b0);
                    add_beat(KIND_ECHO, CHR_SPACE, 1'b0);
                    add_beat(KIND_ECHO, KEY_BACK, 1'b1);
                end
            end
            else if (fill < LINE_MAX)
            begin
                line_copy[fill] = c;
                fill++;
                add_beat(KIND_ECHO, c, 1'b1);
            end
            else
            begin
                dropped++;
            end
            return pending.size() - before_size;
        endfunction

        function void check_result(logic [1:0] k, logic [7:0] b, logic l);
            sle_res_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected beat: kind %0d, out_byte %02h, last %0b", k, b, l);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (k !== want.kind)
            begin
                $error("kind: expected %0d, actual %0d", want.kind, k);
                errors++;
            end
            if (b !== want.out_byte)
            begin
                $error("out_byte: expected %02h, actual %02h", want.out_byte, b);
                errors++;
            end
            if (l !== want.last)
            begin
                $error("last: expected %0b, actual %0b", want.last, l);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       rx_valid = 1'b0;
    logic       rx_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;

    line_scoreboard board = new();

    // Idling odds for each side, in percent, changed between phases by the main sequence.
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    // Remaining cycles of a forced hold-off; the receiver process counts it down.
    int hold_left = 0;
    // Bytes accepted that caused at least one beat.
    int useful_items = 0;
    int cycles = 0;

    serial_line_editor_top #(
        .MAX_LEN(LINE_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .rx_valid(rx_valid),
        .rx_stall(rx_stall),
        .rx_byte(rx_byte),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .kind(kind),
        .out_byte(out_byte),
        .last(last)
    );

    always #HALF_PERIOD clk = ~clk;

    // Watchdog: a hung handshake must not leave the run spinning for ever.
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("serial_line_editor_top: mismatch");
                $finish;
            end
        end
    end

    // Result side. Outputs are sampled at the rising edge, and the stall decision for the
    // next edge is taken at the falling edge. A pending hold-off overrides the random
    // stalling, so the block backs up and has to stall its own input.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res_valid && !res_stall)
            begin
                board.check_result(kind, out_byte, last);
            end
            @(negedge clk);
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                res_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Offers one byte, with random idle cycles first, and waits until it is taken.
    // The valid line is only ever written once per falling edge, so back-to-back beats
    // keep it high without a glitch.
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            rx_valid <= 1'b0;
            @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (rx_stall)
        begin
            @(posedge clk);
        end
        if (board.note_byte(b) > 0)
        begin
            useful_items++;
        end
    endtask

    // Types one line of the given length and, most of the time, ends it with enter.
    // Plain lines carry ordinary bytes only; otherwise backspaces and raw noise bytes
    // (which may themselves be enter or backspace) are mixed in.
    task automatic send_line(input int len, input bit plain);
        logic [7:0] b;
        int pick;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(99);
            b = $urandom_range(255);
            if (!plain && pick < 10)
            begin
                b = KEY_BACK;
            end
            else if (plain || pick >= 13)
            begin
                // Ordinary character: steer clear of the two control codes.
                if (b == KEY_BACK || b == KEY_ENTER)
                begin
                    b = b ^ 8'h40;
                end
            end
            send_byte(b);
        end
        // A few lines are left unfinished, so the next one carries on from them.
        if (plain || $urandom_range(99) >= 6)
        begin
            send_byte(KEY_ENTER);
        end
    endtask

    initial
    begin
        int idle_set  [4];
        int stall_set [4];
        int target;
        idle_set  = '{0, 79, 0, 18};
        stall_set = '{0, 0, 79, 18};

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening: enter and backspace on an empty line, the byte extremes
        // including zero, a backspace on a real line and a short line dump.
        send_byte(KEY_ENTER);
        send_byte(KEY_BACK);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(KEY_BACK);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h01);
        send_byte(KEY_ENTER);
        send_byte(8'h20);
        send_byte(KEY_BACK);
        send_byte(KEY_BACK);
        send_byte(KEY_ENTER);
        send_byte(8'h00);
        send_byte(KEY_ENTER);

        // Random phases, one per idling pattern.
        for (int ph = 0; ph < 4; ph++)
        begin
            sender_idle_pct = idle_set[ph];
            recv_stall_pct = stall_set[ph];
            target = useful_items + PHASE_ITEMS;
            if (ph == 0)
            begin
                // Overfill a line so that bytes are dropped on a full store and the
                // longest dump follows; the receiver holds off meanwhile.
                hold_left = HOLD_CYCLES;
                send_line(LINE_MAX + 4, 1'b1);
            end
            while (useful_items < target)
            begin
                if ($urandom_range(99) < 20)
                begin
                    send_line($urandom_range(LINE_MAX + 8, LINE_MAX - 4), 1'b0);
                end
                else
                begin
                    send_line($urandom_range(10, 0), 1'b0);
                end
            end
        end

        @(negedge clk);
        rx_valid <= 1'b0;

        // Drain: every expected beat must arrive, then a short quiet spell catches strays.
        while (board.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.pending.size() != 0)
        begin
            $error("%0d expected beats never arrived", board.pending.size());
            board.errors++;
        end

        $display("Run covered %0d effective bytes, %0d beats checked, %0d lines dumped,",
                 useful_items, board.checked, board.lines_dumped);
        $display("and %0d bytes dropped on a full line, in %0d cycles.", board.dropped, cycles);
        if (board.errors == 0)
        begin
            $display("serial_line_editor_top: match");
        end
        else
        begin
            $display("serial_line_editor_top: mismatch");
        end
        $finish;
    end

endmodule
